FILE: rtl/ptw_pkg.sv
`timescale 1ns / 1ps

package ptw_pkg;

  localparam int unsigned VaW     = 64;
  localparam int unsigned PaW     = 48;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 48;

  localparam logic [63:0] OaMask = 64'h0000_ffff_ffff_f000;

  localparam logic [1:0] LastLevel = 2'd3;

  // descriptor type in bits [1:0]
  localparam logic [1:0] DescInvalid = 2'd0;
  localparam logic [1:0] DescBlock   = 2'd1;
  localparam logic [1:0] DescPage    = 2'd3;

  localparam logic ReqTranslate = 1'b0;
  localparam logic ReqResponse  = 1'b1;

  localparam logic KindRead = 1'b0;
  localparam logic KindDone = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgTableBase  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStartLevel = 2'd1;

  typedef struct packed {
    logic          req_type;
    logic [63:0]   virt_addr;
    logic [63:0]   entry_word;
  } ptw_req_t;

  typedef struct packed {
    logic          resp_kind;
    logic [63:0]   address;
    logic          mapped;
  } ptw_resp_t;

  typedef struct packed {
    logic           busy;
    logic [1:0]     level;
    logic [VaW-1:0] vaddr;
    logic [PaW-1:0] tbl;
  } ptw_state_t;

  typedef struct packed {
    logic [PaW-1:0] table_base;
    logic [1:0]     start_level;
  } ptw_cfg_t;

  // nine index bits of va for a level, shift is (3 - level) * 9 + 12
  function automatic logic [8:0] level_index(logic [63:0] va, logic [1:0] lvl);
    logic [8:0] idx;
    case (lvl)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

  // offset bits below the output address for a level
  function automatic logic [63:0] low_mask(logic [1:0] lvl);
    logic [63:0] m;
    case (lvl)
      2'd0:    m = 64'h0000_007f_ffff_ffff;
      2'd1:    m = 64'h0000_0000_3fff_ffff;
      2'd2:    m = 64'h0000_0000_001f_ffff;
      default: m = 64'h0000_0000_0000_0fff;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/ptw_step.sv
`timescale 1ns / 1ps

module ptw_step (
  input  ptw_pkg::ptw_req_t   req_i,
  input  ptw_pkg::ptw_state_t state_i,
  input  ptw_pkg::ptw_cfg_t   cfg_i,
  output logic                res_valid_o,
  output ptw_pkg::ptw_resp_t  res_o,
  output ptw_pkg::ptw_state_t state_o
);
  import ptw_pkg::*;

  logic [1:0]  desc_type;
  logic [63:0] lmask;
  logic [63:0] pa;
  logic        emit_read;
  logic [8:0]  idx;
  logic [PaW:0] rd_addr;
  logic [63:0] done_addr;
  logic        done_mapped;

  assign desc_type = req_i.entry_word[1:0];
  assign lmask     = low_mask(state_i.level);
  assign pa        = (req_i.entry_word & ~lmask & OaMask) | (state_i.vaddr & lmask);

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    emit_read   = 1'b0;
    done_addr   = state_i.vaddr;
    done_mapped = 1'b0;
    if (req_i.req_type == ReqTranslate) begin
      if (!state_i.busy) begin
        state_o.busy  = 1'b1;
        state_o.level = cfg_i.start_level;
        state_o.vaddr = req_i.virt_addr;
        state_o.tbl   = cfg_i.table_base;
        emit_read     = 1'b1;
      end
    end else if (state_i.busy) begin
      res_valid_o = 1'b1;
      if (desc_type == DescInvalid) begin
        state_o.busy = 1'b0;
      end else if (desc_type == DescBlock ||
                   (desc_type == DescPage && state_i.level == LastLevel)) begin
        state_o.busy = 1'b0;
        done_addr    = pa;
        done_mapped  = 1'b1;
      end else if (state_i.level == LastLevel) begin
        // table descriptor at the last level ends unmapped
        state_o.busy = 1'b0;
      end else begin
        state_o.tbl   = req_i.entry_word[PaW-1:0] & OaMask[PaW-1:0];
        state_o.level = state_i.level + 2'd1;
        emit_read     = 1'b1;
      end
    end
    if (emit_read) begin
      res_valid_o = 1'b1;
    end
  end

  // read address follows the state that the request leaves behind
  assign idx     = level_index(state_o.vaddr, state_o.level);
  assign rd_addr = {1'b0, state_o.tbl} + {{(PaW-11){1'b0}}, idx, 3'b000};

  assign res_o = emit_read ?
                 ptw_resp_t'{resp_kind: KindRead,
                             address:   {{(64-PaW-1){1'b0}}, rd_addr},
                             mapped:    1'b0} :
                 ptw_resp_t'{resp_kind: KindDone,
                             address:   done_addr,
                             mapped:    done_mapped};

endmodule

FILE: rtl/ptw_out_reg.sv
`timescale 1ns / 1ps

module ptw_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               res_valid_i,
  input  ptw_pkg::ptw_resp_t res_i,
  output logic               adv_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ptw_pkg::ptw_resp_t out_resp_o
);
  import ptw_pkg::*;

  logic      valid_q, valid_d;
  ptw_resp_t data_q;

  // register may take a new result when empty or being drained
  assign adv_o   = !valid_q || !out_stall_i;
  assign valid_d = adv_o ? res_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_resp_o  = data_q;

endmodule

FILE: rtl/page_table_walker_top.sv
`timescale 1ns / 1ps

// channel | direction | handshake             | payload
// in      | input     | in_valid_i / in_stall_o   | in_req_i    (ptw_req_t)
// out     | output    | out_valid_o / out_stall_i | out_resp_o  (ptw_resp_t)
// cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// one request per cycle sustained while the result register is not stalled;
// a request's result, if any, goes into the result register from the input register
// the walk state is updated by one short decode step per request, so a response
// can follow its read request in the very next cycle
// reset clears valids, walk state and configuration; no clearing pass
// in_stall_o rises only while a request is held and the result register is stalled

module page_table_walker_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ptw_pkg::ptw_req_t              in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ptw_pkg::ptw_resp_t             out_resp_o,
  input  logic                           cfg_we_i,
  input  logic [ptw_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ptw_pkg::CfgW-1:0]       cfg_wdata_i
);
  import ptw_pkg::*;

  logic       in_valid_q;
  ptw_req_t   in_req_q;
  ptw_state_t state_q, state_d;
  ptw_cfg_t   cfg_q, cfg_d;
  logic       res_valid;
  ptw_resp_t  res;
  logic       adv;
  logic       proc;

  assign in_stall_o = in_valid_q && !adv;
  assign proc       = in_valid_q && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_req_q <= in_req_i;
    end
  end

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTableBase:  cfg_d.table_base  = cfg_wdata_i[PaW-1:0];
        CfgStartLevel: cfg_d.start_level = cfg_wdata_i[1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= '0;
      state_q <= '0;
    end else begin
      cfg_q <= cfg_d;
      if (proc) begin
        state_q <= state_d;
      end
    end
  end

  ptw_step u_step (
    .req_i       (in_req_q),
    .state_i     (state_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res),
    .state_o     (state_d)
  );

  ptw_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (proc && res_valid),
    .res_i       (res),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_resp_o  (out_resp_o)
  );

`ifndef SYNTHESIS
  // a response arriving with no walk open gives nothing
  a_idle_resp_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && in_req_q.req_type == ReqResponse && !state_q.busy |=> !out_valid_o)
    else $error("response while idle produced a result");

  // an accepted translate opens a walk
  a_translate_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && in_req_q.req_type == ReqTranslate && !state_q.busy |=> state_q.busy)
    else $error("translate did not start a walk");

  // a walk that continues after a response has gone one level down
  a_descend_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && state_q.busy && in_req_q.req_type == ReqResponse && state_d.busy
    |=> state_q.level == $past(state_q.level) + 2'd1)
    else $error("walk continued without descending");

  // input is held back only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with the result register free");
`endif

endmodule
